// ----- design/mtq_pkg.sv -----
`timescale 1ns / 1ps
package mtq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // One stack slot: the value and the minimum of it and everything below it
  typedef struct packed {
    data_t val;
    data_t mn;
  } entry_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

endpackage

// ----- design/mtq_cell.sv -----
`timescale 1ns / 1ps
module mtq_cell (
  input  logic             clk,
  input  mtq_pkg::stk_op_t op,
  input  mtq_pkg::entry_t  from_above,
  input  mtq_pkg::entry_t  from_below,
  output mtq_pkg::entry_t  q
);

  mtq_pkg::entry_t q_r;

  // push shifts the column down, pop shifts it up
  always_ff @(posedge clk) begin
    unique case (op)
      mtq_pkg::STK_PUSH: q_r <= from_above;
      mtq_pkg::STK_POP:  q_r <= from_below;
      default:           q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule

// ----- design/mtq_stack.sv -----
`timescale 1ns / 1ps
module mtq_stack (
  input  logic             clk,
  input  logic             rst_n,
  input  mtq_pkg::stk_op_t op,
  input  mtq_pkg::data_t   push_val,
  output mtq_pkg::entry_t  top,
  output mtq_pkg::cnt_t    count
);

  mtq_pkg::entry_t cell_q [mtq_pkg::DEPTH];
  mtq_pkg::entry_t new_entry;
  mtq_pkg::cnt_t   count_r;
  mtq_pkg::cnt_t   count_nxt;

  // running minimum of the new top against the current top
  always_comb begin
    new_entry.val = push_val;
    if (count_r != '0 && cell_q[0].mn < push_val) begin
      new_entry.mn = cell_q[0].mn;
    end else begin
      new_entry.mn = push_val;
    end
  end

  for (genvar i = 0; i < mtq_pkg::DEPTH; i++) begin : g_cell
    mtq_pkg::entry_t above;
    mtq_pkg::entry_t below;
    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == mtq_pkg::DEPTH - 1) begin : g_bot
      assign below = cell_q[i];
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    mtq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  always_comb begin
    unique case (op)
      mtq_pkg::STK_PUSH: count_nxt = count_r + mtq_pkg::CNT_W'(1);
      mtq_pkg::STK_POP:  count_nxt = count_r - mtq_pkg::CNT_W'(1);
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top   = cell_q[0];
  assign count = count_r;

endmodule

// ----- design/min_tracking_queue.sv -----
`timescale 1ns / 1ps
// First-in first-out queue of signed 32-bit values with a running minimum.
// Input: drive in_kind (push or pop) and in_value with start; the beat is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been issued, so one operation is in flight at a time.
// Output: out_valid is high for exactly one cycle per input beat and carries
// popped value, front, back, minimum, occupancy, empty and error flags as they
// stand after the operation. The receiver cannot stall; a result not taken in
// its cycle is gone.
// Steps: the beat is registered at accept, the stacks act in the execute
// state, and the result is registered in the report state. A pop that finds
// the pop side empty first moves the push side across one entry per cycle
// through the two cell columns, then pops the pop side before it reports.
// Capacity is 16 values; a push on a full queue or a pop on an empty one
// reports error and changes nothing.
// Reset (rst_n low, synchronous) empties both stacks and clears the strobe.
module min_tracking_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  output logic signed [31:0]   out_popped_value,
  output logic signed [31:0]   out_front_value,
  output logic signed [31:0]   out_back_value,
  output logic signed [31:0]   out_min_value,
  output logic [4:0]           out_occupancy,
  output logic                 out_is_empty,
  output logic                 out_error
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_XFER,
    S_POP,
    S_REPORT
  } state_t;

  state_t           state_r;
  logic             kind_r;
  mtq_pkg::data_t   value_r;
  mtq_pkg::data_t   push_first_r;
  mtq_pkg::data_t   pop_last_r;
  mtq_pkg::data_t   popped_r;
  logic             err_r;

  logic             out_valid_r;
  mtq_pkg::data_t   out_popped_r;
  mtq_pkg::data_t   out_front_r;
  mtq_pkg::data_t   out_back_r;
  mtq_pkg::data_t   out_min_r;
  mtq_pkg::cnt_t    out_occ_r;
  logic             out_empty_r;
  logic             out_err_r;

  mtq_pkg::stk_op_t push_op;
  mtq_pkg::stk_op_t pop_op;
  mtq_pkg::data_t   pop_in_val;
  mtq_pkg::entry_t  push_top;
  mtq_pkg::entry_t  pop_top;
  mtq_pkg::cnt_t    push_cnt;
  mtq_pkg::cnt_t    pop_cnt;
  mtq_pkg::cnt_t    total;

  mtq_pkg::data_t   front_nxt;
  mtq_pkg::data_t   back_nxt;
  mtq_pkg::data_t   min_nxt;

  assign total = push_cnt + pop_cnt;

  // stack commands per state
  always_comb begin
    push_op    = mtq_pkg::STK_HOLD;
    pop_op     = mtq_pkg::STK_HOLD;
    pop_in_val = push_top.val;
    unique case (state_r)
      S_EXEC: begin
        if (kind_r == mtq_pkg::KIND_PUSH) begin
          if (total < mtq_pkg::CNT_W'(mtq_pkg::DEPTH)) begin
            push_op = mtq_pkg::STK_PUSH;
          end
        end else if (pop_cnt != '0) begin
          pop_op = mtq_pkg::STK_POP;
        end
      end
      S_XFER: begin
        push_op = mtq_pkg::STK_POP;
        pop_op  = mtq_pkg::STK_PUSH;
      end
      S_POP: begin
        pop_op = mtq_pkg::STK_POP;
      end
      default: begin
      end
    endcase
  end

  mtq_stack u_push_stk (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (push_op),
    .push_val (value_r),
    .top      (push_top),
    .count    (push_cnt)
  );

  mtq_stack u_pop_stk (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (pop_op),
    .push_val (pop_in_val),
    .top      (pop_top),
    .count    (pop_cnt)
  );

  // report fields from the settled state
  always_comb begin
    front_nxt = '0;
    back_nxt  = '0;
    min_nxt   = '0;
    if (total != '0) begin
      front_nxt = (pop_cnt == '0) ? push_first_r : pop_top.val;
      back_nxt  = (push_cnt == '0) ? pop_last_r : push_top.val;
      if (push_cnt == '0) begin
        min_nxt = pop_top.mn;
      end else if (pop_cnt == '0) begin
        min_nxt = push_top.mn;
      end else begin
        min_nxt = (push_top.mn < pop_top.mn) ? push_top.mn : pop_top.mn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      push_first_r <= '0;
      pop_last_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r   <= in_kind;
            value_r  <= in_value;
            popped_r <= '0;
            err_r    <= 1'b0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_REPORT;
          if (kind_r == mtq_pkg::KIND_PUSH) begin
            if (total >= mtq_pkg::CNT_W'(mtq_pkg::DEPTH)) begin
              err_r <= 1'b1;
            end else if (push_cnt == '0) begin
              push_first_r <= value_r;
            end
          end else if (total == '0) begin
            err_r <= 1'b1;
          end else if (pop_cnt == '0) begin
            // pop side dry: move the push side across first
            pop_last_r   <= push_top.val;
            push_first_r <= '0;
            state_r      <= S_XFER;
          end else begin
            popped_r <= pop_top.val;
          end
        end
        S_XFER: begin
          if (push_cnt == mtq_pkg::CNT_W'(1)) begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          popped_r <= pop_top.val;
          state_r  <= S_REPORT;
        end
        S_REPORT: begin
          out_valid_r  <= 1'b1;
          out_popped_r <= popped_r;
          out_front_r  <= front_nxt;
          out_back_r   <= back_nxt;
          out_min_r    <= min_nxt;
          out_occ_r    <= total;
          out_empty_r  <= (total == '0);
          out_err_r    <= err_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_min_value    = out_min_r;
  assign out_occupancy    = out_occ_r;
  assign out_is_empty     = out_empty_r;
  assign out_error        = out_err_r;

endmodule

// ----- design/mtq_checker.sv -----
`timescale 1ns / 1ps
module mtq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_kind,
  input logic                out_valid,
  input logic signed [31:0]  out_front_value,
  input logic signed [31:0]  out_back_value,
  input logic signed [31:0]  out_min_value,
  input logic [4:0]          out_occupancy,
  input logic                out_is_empty
);

  // a beat goes in only when the block is free, and it stays busy after
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // a push always reports through the execute and report states, with no transfer
  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == mtq_pkg::KIND_PUSH) |-> ##3 out_valid)
    else $error("push result missing at expected cycle");

  // one strobe per beat, never two in a row
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_occupancy == '0 && out_front_value == '0 && out_back_value == '0 &&
       out_min_value == '0))
    else $error("empty queue reported with nonzero fields");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= 5'(mtq_pkg::DEPTH) &&
                   out_is_empty == (out_occupancy == '0)))
    else $error("occupancy out of range or disagrees with empty flag");

endmodule

bind min_tracking_queue mtq_checker u_mtq_checker (.*);
